### hw/rtl/ovd_pkg.sv
package ovd_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int DOY_W   = 9;
    localparam int DAYS_W  = 22;
    localparam int CUM_W   = 9;

    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
    localparam logic [DAYS_W-1:0] DAYS_MAX = 22'd4194303;

    // floor(y / 100) = (y * 5243) >> 19, exact for every 14-bit y
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP_W     = YEAR_W + 13;
    localparam int QUO_W       = 8;
    localparam logic [RECIP_W-1:0] RECIP_100 = 27'd5243;

    localparam logic [MONTH_W-1:0] MONTH_MAR  = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_PAST = 4'd13;

    // days in the months of a year that come before month m; months past
    // December count the whole year, month zero and January count nothing
    function automatic logic [CUM_W-1:0] cum_before(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [CUM_W-1:0] base;
        begin
            unique case (m)
                4'd0:    base = 9'd0;
                4'd1:    base = 9'd0;
                4'd2:    base = 9'd31;
                4'd3:    base = 9'd59;
                4'd4:    base = 9'd90;
                4'd5:    base = 9'd120;
                4'd6:    base = 9'd151;
                4'd7:    base = 9'd181;
                4'd8:    base = 9'd212;
                4'd9:    base = 9'd243;
                4'd10:   base = 9'd273;
                4'd11:   base = 9'd304;
                4'd12:   base = 9'd334;
                default: base = 9'd365;
            endcase
            cum_before = base + {8'd0, (leap && (m >= MONTH_MAR))};
        end
    endfunction

endpackage

### hw/rtl/overdue_day_counter_unit.sv
// Overdue day counter.
// Input channel (in_valid/in_ready): one beat holds a due date (day, month,
// year) and today's date (day, month, year, day of year). Output channel
// (out_valid/out_ready): one beat per input beat with is_late, set when the
// due date lies strictly before today, and days_overdue, the Gregorian day
// count from the due date to today (0 when not late or when the sum falls below zero, clipped at 4194303).
// Years above 9999 are treated as 9999.
// Four register stages: year quotients by 100, leap flags and month tables,
// year span times 365, then the final sum and clip in the output register.
// A new beat is taken every cycle while the output is not stalled. All stages
// share one enable: when out_valid is high and out_ready is low the whole pipe
// holds and in_ready drops, so nothing is lost or repeated.
// Reset clears every stage valid bit; out_valid is low after reset.
module overdue_day_counter_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ovd_pkg::DAY_W-1:0]         due_day,
    input  logic [ovd_pkg::MONTH_W-1:0]       due_month,
    input  logic [ovd_pkg::YEAR_W-1:0]        due_year,
    input  logic [ovd_pkg::DAY_W-1:0]         today_day,
    input  logic [ovd_pkg::MONTH_W-1:0]       today_month,
    input  logic [ovd_pkg::YEAR_W-1:0]        today_year,
    input  logic [ovd_pkg::DOY_W-1:0]         today_day_of_year,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              is_late,
    output logic [ovd_pkg::DAYS_W-1:0]        days_overdue
);

    localparam int YW   = ovd_pkg::YEAR_W;
    localparam int QW   = ovd_pkg::QUO_W;
    localparam int YD_W = 23;
    localparam int HD_W = 12;
    localparam int TT_W = 25;

    logic advance;

    // stage 1
    logic                        v1_reg;
    logic [ovd_pkg::DAY_W-1:0]   dd1_reg, td1_reg;
    logic [ovd_pkg::MONTH_W-1:0] dm1_reg, tm1_reg;
    logic [ovd_pkg::DOY_W-1:0]   doy1_reg;
    logic [YW-1:0]               dy1_reg, n1_reg;
    logic [QW-1:0]               qdy1_reg, qn1_reg;
    logic                        late1_reg, same1_reg;

    // stage 2
    logic                        v2_reg;
    logic [ovd_pkg::DAY_W-1:0]   dd2_reg, td2_reg;
    logic [ovd_pkg::DOY_W-1:0]   doy2_reg;
    logic [YW-1:0]               span2_reg, ld2_reg;
    logic [ovd_pkg::CUM_W-1:0]   cbd2_reg, cbe2_reg;
    logic                        late2_reg, same2_reg;

    // stage 3
    logic                        v3_reg;
    logic [YD_W-1:0]             yd3_reg;
    logic signed [HD_W-1:0]      head3_reg;
    logic                        late3_reg, same3_reg;

    // stage 4 (output)
    logic                        v4_reg;
    logic                        late4_reg;
    logic [ovd_pkg::DAYS_W-1:0]  days4_reg;

    // stage 1 logic
    logic [YW-1:0]               dy_c, ty_c, n_c;
    logic [ovd_pkg::RECIP_W-1:0] prod_dy, prod_n;
    logic                        late_c;

    // stage 2 logic
    logic [YW-1:0]               r100, leaps_n, leaps_dy;
    logic                        leap_dy;

    // stage 3 logic
    logic signed [HD_W-1:0]      head_c;

    // stage 4 logic
    logic signed [TT_W-1:0]      total_c;
    logic [ovd_pkg::DAYS_W-1:0]  days_next;

    assign advance  = !v4_reg || out_ready;
    assign in_ready = advance;

    always_comb
    begin
        dy_c = (due_year > ovd_pkg::YEAR_MAX) ? ovd_pkg::YEAR_MAX : due_year;
        ty_c = (today_year > ovd_pkg::YEAR_MAX) ? ovd_pkg::YEAR_MAX : today_year;
        n_c  = ty_c - 14'd1;
        prod_dy = {13'd0, dy_c} * ovd_pkg::RECIP_100;
        prod_n  = {13'd0, n_c} * ovd_pkg::RECIP_100;
        priority if (dy_c != ty_c)
            late_c = dy_c < ty_c;
        else if (due_month != today_month)
            late_c = due_month < today_month;
        else
            late_c = due_day < today_day;
    end

    always_comb
    begin
        r100    = dy1_reg - ({6'd0, qdy1_reg} * 14'd100);
        // at a century the year is leap when its century count divides by 4
        leap_dy = (r100 == '0) ? (qdy1_reg[1:0] == 2'd0) : (dy1_reg[1:0] == 2'd0);
        leaps_n  = (n1_reg >> 2) - {6'd0, qn1_reg} + {8'd0, qn1_reg[QW-1:2]};
        leaps_dy = (dy1_reg >> 2) - {6'd0, qdy1_reg} + {8'd0, qdy1_reg[QW-1:2]};
    end

    always_comb
    begin
        head_c = $signed({3'd0, cbe2_reg}) - $signed({3'd0, cbd2_reg})
               - $signed({7'd0, dd2_reg})
               + (same2_reg ? $signed({7'd0, td2_reg}) : $signed({3'd0, doy2_reg}));
    end

    always_comb
    begin
        total_c = TT_W'(head3_reg);
        if (!same3_reg)
        begin
            total_c = total_c + $signed({2'd0, yd3_reg});
        end
        priority if (!late3_reg)
            days_next = '0;
        else if (total_c < 0)
            days_next = '0;
        else if (total_c > $signed({3'd0, ovd_pkg::DAYS_MAX}))
            days_next = ovd_pkg::DAYS_MAX;
        else
            days_next = total_c[ovd_pkg::DAYS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dd1_reg   <= due_day;
            dm1_reg   <= due_month;
            td1_reg   <= today_day;
            tm1_reg   <= today_month;
            doy1_reg  <= today_day_of_year;
            dy1_reg   <= dy_c;
            n1_reg    <= n_c;
            qdy1_reg  <= prod_dy[ovd_pkg::RECIP_SHIFT +: QW];
            qn1_reg   <= prod_n[ovd_pkg::RECIP_SHIFT +: QW];
            late1_reg <= late_c;
            same1_reg <= (dy_c == ty_c);

            dd2_reg   <= dd1_reg;
            td2_reg   <= td1_reg;
            doy2_reg  <= doy1_reg;
            span2_reg <= n1_reg - dy1_reg;
            ld2_reg   <= leaps_n - leaps_dy;
            cbd2_reg  <= ovd_pkg::cum_before(dm1_reg, leap_dy);
            cbe2_reg  <= ovd_pkg::cum_before(same1_reg ? tm1_reg : ovd_pkg::MONTH_PAST,
                                             leap_dy);
            late2_reg <= late1_reg;
            same2_reg <= same1_reg;

            yd3_reg   <= ({9'd0, span2_reg} * 23'd365) + {9'd0, ld2_reg};
            head3_reg <= head_c;
            late3_reg <= late2_reg;
            same3_reg <= same2_reg;

            late4_reg <= late3_reg;
            days4_reg <= days_next;
        end
    end

    assign out_valid    = v4_reg;
    assign is_late      = late4_reg;
    assign days_overdue = days4_reg;

endmodule

### verif/overdue_day_counter_unit_test.sv
`timescale 1ns / 100ps

module overdue_day_counter_unit_test;

    typedef struct packed {
        logic [ovd_pkg::DAY_W-1:0]   due_d;
        logic [ovd_pkg::MONTH_W-1:0] due_m;
        logic [ovd_pkg::YEAR_W-1:0]  due_y;
        logic [ovd_pkg::DAY_W-1:0]   now_d;
        logic [ovd_pkg::MONTH_W-1:0] now_m;
        logic [ovd_pkg::YEAR_W-1:0]  now_y;
        logic [ovd_pkg::DOY_W-1:0]   now_doy;
    } dates_t;

    typedef struct packed {
        logic                       late;
        logic [ovd_pkg::DAYS_W-1:0] days;
    } verdict_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic [ovd_pkg::DAY_W-1:0]    due_day;
    logic [ovd_pkg::MONTH_W-1:0]  due_month;
    logic [ovd_pkg::YEAR_W-1:0]   due_year;
    logic [ovd_pkg::DAY_W-1:0]    today_day;
    logic [ovd_pkg::MONTH_W-1:0]  today_month;
    logic [ovd_pkg::YEAR_W-1:0]   today_year;
    logic [ovd_pkg::DOY_W-1:0]    today_day_of_year;
    logic                         out_valid;
    logic                         out_ready;
    logic                         is_late;
    logic [ovd_pkg::DAYS_W-1:0]   days_overdue;

    verdict_t pending_verdicts[$];
    int       mismatch_count = 0;
    bit       tx_idle_on = 1'b1;
    bit       rx_stall_on = 1'b1;

    overdue_day_counter_unit i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .due_day           (due_day),
        .due_month         (due_month),
        .due_year          (due_year),
        .today_day         (today_day),
        .today_month       (today_month),
        .today_year        (today_year),
        .today_day_of_year (today_day_of_year),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .is_late           (is_late),
        .days_overdue      (days_overdue)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------- calendar

    function automatic bit has_feb_29(input int unsigned y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    // months outside 1..12 hold no days
    function automatic int month_days(input int unsigned m, input int unsigned y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return has_feb_29(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic int unsigned day_of_year(input int unsigned d, input int unsigned m,
                                                input int unsigned y);
        int unsigned s;
        s = d;
        for (int unsigned k = 1; k < m; k++)
            s += month_days(k, y);
        return s;
    endfunction

    function automatic verdict_t predict_verdict(input dates_t b);
        int unsigned dy;
        int unsigned ty;
        int          sum;
        verdict_t    v;
        dy = int'((b.due_y > ovd_pkg::YEAR_MAX) ? ovd_pkg::YEAR_MAX : b.due_y);
        ty = int'((b.now_y > ovd_pkg::YEAR_MAX) ? ovd_pkg::YEAR_MAX : b.now_y);
        if (dy != ty)
            v.late = dy < ty;
        else if (b.due_m != b.now_m)
            v.late = b.due_m < b.now_m;
        else
            v.late = b.due_d < b.now_d;
        sum = 0;
        if (v.late)
        begin
            if (dy == ty && b.due_m == b.now_m)
                sum = int'(b.now_d) - int'(b.due_d);
            else
            begin
                sum = month_days(int'(b.due_m), dy) - int'(b.due_d);
                if (dy == ty)
                begin
                    for (int unsigned m = int'(b.due_m) + 1; m < int'(b.now_m); m++)
                        sum += month_days(m, dy);
                    sum += int'(b.now_d);
                end
                else
                begin
                    for (int unsigned m = int'(b.due_m) + 1; m <= 12; m++)
                        sum += month_days(m, dy);
                    for (int unsigned y = dy + 1; y < ty; y++)
                        sum += has_feb_29(y) ? 366 : 365;
                    sum += int'(b.now_doy);
                end
            end
            if (sum < 0)
                sum = 0;
            if (sum > int'(ovd_pkg::DAYS_MAX))
                sum = int'(ovd_pkg::DAYS_MAX);
        end
        v.days = v.late ? sum[ovd_pkg::DAYS_W-1:0] : '0;
        return v;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic dates_t mk_dates(input int dd, input int dm, input int dy,
                                        input int td, input int tm, input int ty,
                                        input int tdoy);
        dates_t b;
        b.due_d   = dd[ovd_pkg::DAY_W-1:0];
        b.due_m   = dm[ovd_pkg::MONTH_W-1:0];
        b.due_y   = dy[ovd_pkg::YEAR_W-1:0];
        b.now_d   = td[ovd_pkg::DAY_W-1:0];
        b.now_m   = tm[ovd_pkg::MONTH_W-1:0];
        b.now_y   = ty[ovd_pkg::YEAR_W-1:0];
        b.now_doy = tdoy[ovd_pkg::DOY_W-1:0];
        return b;
    endfunction

    // two real dates, mostly due before today, spans from days to millennia
    function automatic dates_t calendar_pair();
        int unsigned kind, y0, y1, m0, m1, d0, d1, t, doy;
        kind = $urandom_range(0, 9);
        y0 = ($urandom_range(0, 5) == 0) ? 100 * $urandom_range(1, 99)
                                         : $urandom_range(1, 9999);
        m0 = $urandom_range(1, 12);
        m1 = $urandom_range(1, 12);
        case (kind)
            0, 1, 2:
            begin
                y1 = y0;
                m1 = m0;
            end
            3, 4:    y1 = y0;
            5, 6, 7: y1 = y0 + $urandom_range(1, 4);
            8:       y1 = y0 + $urandom_range(1, 450);
            default: y1 = $urandom_range(1, 9999);
        endcase
        if (y1 > 9999)
            y1 = 9999;
        d0 = $urandom_range(1, month_days(m0, y0));
        d1 = $urandom_range(1, month_days(m1, y1));
        if (kind == 0 && $urandom_range(0, 3) == 0)
            d1 = d0;
        if ($urandom_range(0, 4) == 0)
        begin
            t = y0; y0 = y1; y1 = t;
            t = m0; m0 = m1; m1 = t;
            t = d0; d0 = d1; d1 = t;
        end
        doy = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : day_of_year(d1, m1, y1);
        return mk_dates(d0, m0, y0, d1, m1, y1, doy);
    endfunction

    function automatic dates_t noise_pair();
        return mk_dates(int'($urandom_range(0, (1 << ovd_pkg::DAY_W) - 1)),
                        int'($urandom_range(0, (1 << ovd_pkg::MONTH_W) - 1)),
                        int'($urandom_range(0, (1 << ovd_pkg::YEAR_W) - 1)),
                        int'($urandom_range(0, (1 << ovd_pkg::DAY_W) - 1)),
                        int'($urandom_range(0, (1 << ovd_pkg::MONTH_W) - 1)),
                        int'($urandom_range(0, (1 << ovd_pkg::YEAR_W) - 1)),
                        int'($urandom_range(0, (1 << ovd_pkg::DOY_W) - 1)));
    endfunction

    // a real pair with one field swapped for garbage
    function automatic dates_t broken_pair();
        dates_t b;
        dates_t junk;
        b = calendar_pair();
        junk = noise_pair();
        case ($urandom_range(0, 6))
            0:       b.due_d = junk.due_d;
            1:       b.due_m = junk.due_m;
            2:       b.due_y = junk.due_y;
            3:       b.now_d = junk.now_d;
            4:       b.now_m = junk.now_m;
            5:       b.now_y = junk.now_y;
            default: b.now_doy = junk.now_doy;
        endcase
        return b;
    endfunction

    // called at a rising edge; returns at the edge after the beat (and any gap)
    task automatic send_dates(input dates_t b);
        in_valid          <= 1'b1;
        due_day           <= b.due_d;
        due_month         <= b.due_m;
        due_year          <= b.due_y;
        today_day         <= b.now_d;
        today_month       <= b.now_m;
        today_year        <= b.now_y;
        today_day_of_year <= b.now_doy;
        do
            @(posedge clk);
        while (!in_ready);
        pending_verdicts.push_back(predict_verdict(b));
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_field_extremes();
        send_dates(mk_dates(1, 1, 1, 1, 1, 1, 1));               // equal, not late
        send_dates(mk_dates(31, 12, 9999, 1, 1, 1, 1));          // due after today
        send_dates(mk_dates(1, 1, 1, 31, 12, 9999, 365));        // widest real span
        send_dates(mk_dates(0, 0, 0, 31, 15, 16383, 511));       // all-zero vs all-ones
        send_dates(mk_dates(28, 2, 0, 1, 3, 0, 61));             // year zero is leap
        send_dates(mk_dates(5, 6, 16383, 5, 7, 12000, 188));     // both years clip to max
        send_dates(mk_dates(5, 7, 10000, 5, 7, 12000, 186));     // equal after clipping
        send_dates(mk_dates(10, 0, 2020, 5, 1, 2020, 5));        // month zero, sum below zero
        send_dates(mk_dates(4, 13, 2020, 9, 14, 2020, 100));     // months past December
        send_dates(mk_dates(3, 15, 2000, 1, 1, 2001, 1));        // month 15, later year
        send_dates(mk_dates(31, 2, 2023, 1, 3, 2023, 60));       // day past end of month
        send_dates(mk_dates(0, 5, 2024, 0, 6, 2024, 153));       // day zero
        send_dates(mk_dates(0, 5, 2024, 1, 5, 2024, 122));
        send_dates(mk_dates(30, 4, 2024, 31, 4, 2024, 122));
        send_dates(mk_dates(28, 2, 1900, 1, 3, 1900, 60));       // century, not leap
        send_dates(mk_dates(28, 2, 2000, 1, 3, 2000, 61));       // 400 rule
        send_dates(mk_dates(31, 12, 2099, 1, 1, 2101, 1));
        send_dates(mk_dates(1, 1, 2020, 1, 1, 2021, 0));         // day of year zero
        send_dates(mk_dates(1, 1, 2020, 1, 1, 2021, 511));       // day of year too big
        send_dates(mk_dates(20, 8, 2024, 10, 8, 2024, 223));     // earlier day, same month
        send_dates(mk_dates(1, 9, 2024, 30, 8, 2024, 243));      // earlier month
        send_dates(mk_dates(29, 2, 2024, 31, 12, 2024, 366));
    endtask

    task automatic test_calendar_random(input int count);
        repeat (count) send_dates(calendar_pair());
    endtask

    task automatic test_drain_pause();
        repeat (20) send_dates(calendar_pair());
        in_valid <= 1'b0;
        @(posedge clk);
        wait_drained();
        repeat (20) send_dates(calendar_pair());
    endtask

    task automatic test_field_noise(input int count);
        repeat (count) send_dates(($urandom_range(0, 1) == 0) ? noise_pair() : broken_pair());
    endtask

    task automatic test_back_to_back(input int count);
        tx_idle_on  = 1'b0;
        rx_stall_on = 1'b0;
        repeat (count) send_dates(($urandom_range(0, 6) == 0) ? broken_pair() : calendar_pair());
    endtask

    // ---------------------------------------------------------------- result side

    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rx_stall_on && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_verdicts
        verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: expected no beat, got is_late %0d days_overdue %0d",
                         $time, is_late, days_overdue);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (is_late !== want.late)
                begin
                    mismatch_count++;
                    $display("%0t: is_late expected %0d, got %0d",
                             $time, want.late, is_late);
                end
                if (days_overdue !== want.days)
                begin
                    mismatch_count++;
                    $display("%0t: days_overdue expected %0d, got %0d",
                             $time, want.days, days_overdue);
                end
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        due_day           = '0;
        due_month         = '0;
        due_year          = '0;
        today_day         = '0;
        today_month       = '0;
        today_year        = '0;
        today_day_of_year = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_calendar_random(180);
        test_drain_pause();
        test_field_noise(80);
        test_back_to_back(150);

        in_valid <= 1'b0;
        @(posedge clk);
        wait_drained();
        repeat (8) @(posedge clk);
        if (pending_verdicts.size() == 0 && mismatch_count == 0)
            $display("overdue_day_counter_unit_test passed");
        else
            $display("overdue_day_counter_unit_test failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("overdue_day_counter_unit_test failed");
        $finish;
    end

endmodule

### sim.f
hw/rtl/ovd_pkg.sv
hw/rtl/overdue_day_counter_unit.sv
verif/overdue_day_counter_unit_test.sv
